/* src/fpq_pkg.sv */
package fpq_pkg;

  typedef enum logic [3:0] {
    MODE_ADD     = 4'd0,
    MODE_SUB     = 4'd1,
    MODE_MUL     = 4'd2,
    MODE_DIV     = 4'd3,
    MODE_GT      = 4'd4,
    MODE_LT      = 4'd5,
    MODE_GE      = 4'd6,
    MODE_LE      = 4'd7,
    MODE_EQ      = 4'd8,
    MODE_NE      = 4'd9,
    MODE_MIN     = 4'd10,
    MODE_MAX     = 4'd11,
    MODE_INC     = 4'd12,
    MODE_DEC     = 4'd13,
    MODE_TOINT   = 4'd14,
    MODE_FROMINT = 4'd15
  } mode_e;

  localparam int unsigned DataW = 32;

endpackage

/* src/fixed_point_q24_8_alu.sv */
// Signed fixed-point ALU, raw 32-bit operands with FRACTION_BITS fraction bits.
// Input channel: in_valid_i / in_stall_o carry mode_i, operand_a_i, operand_b_i.
// Output channel: out_valid_o / out_stall_i carry result_value_o and the
// compare_true_o, divide_by_zero_o and saturated_o flags.
// Every beat passes the same stages, whatever the mode: an input register,
// one stage per quotient bit of the restoring divider, and the round/clamp
// output register. The multiplier sits between the input register and the
// first divider stage. One beat is accepted every cycle while the pipe
// advances; beats leave in the order they entered.
// The whole pipe advances together: when the output register holds a beat
// and out_stall_i is high, every stage holds and in_stall_o rises in the
// same cycle. An empty output register never stalls the input.
// Reset clears all valid bits; the pipe comes out of reset empty and ready.
// Add, sub, inc, dec and fromint wrap; mul and div round half away from zero
// and clamp with saturated_o; divide by zero gives 0 with divide_by_zero_o.
module fixed_point_q24_8_alu #(
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  fpq_pkg::mode_e              mode_i,
  input  logic signed [31:0]          operand_a_i,
  input  logic signed [31:0]          operand_b_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [31:0]          result_value_o,
  output logic                        compare_true_o,
  output logic                        divide_by_zero_o,
  output logic                        saturated_o
);
  import fpq_pkg::*;

  localparam int unsigned NumW  = DataW + FRACTION_BITS;
  localparam int unsigned Depth = NumW + 1;

  typedef struct packed {
    mode_e             mode;
    logic [DataW-1:0]  res;
    logic              cmp;
    logic              dz;
    logic              neg;
    logic [2*DataW-1:0] prod;
    logic [DataW-1:0]  mag_a;
    logic [DataW-1:0]  den;
    logic [DataW-1:0]  rem;
    logic [NumW-1:0]   num;
    logic [NumW-1:0]   quo;
  } stage_t;

  stage_t           st_q [Depth];
  stage_t           st_d [Depth];
  logic [Depth-1:0] vld_q;
  logic             advance;

  logic [DataW-1:0] res_q;
  logic             cmp_q, dz_q, sat_q, out_vld_q;
  logic [DataW-1:0] res_d;
  logic             sat_d;

  assign advance    = !out_vld_q || !out_stall_i;
  assign in_stall_o = !advance;

  // Clamp a magnitude with sign to 32 bits; returns {sat, value}.
  function automatic logic [DataW:0] clamp(input logic neg, input logic [2*DataW-1:0] mag);
    logic [2*DataW-1:0] lim;
    logic [2*DataW-1:0] neg_mag;
    lim     = {{DataW{1'b0}}, 1'b1, {(DataW-1){1'b0}}};
    neg_mag = -mag;
    if (neg) begin
      if (mag > lim) return {1'b1, 1'b1, {(DataW-1){1'b0}}};
      return {1'b0, neg_mag[DataW-1:0]};
    end
    if (mag >= lim) return {1'b1, 1'b0, {(DataW-1){1'b1}}};
    return {1'b0, mag[DataW-1:0]};
  endfunction

  // Front stage: simple ops, magnitudes and divider setup.
  always_comb begin
    logic signed [DataW-1:0] a, b;
    logic [DataW-1:0] ma, mb;
    a  = operand_a_i;
    b  = operand_b_i;
    ma = a[DataW-1] ? DataW'(-a) : DataW'(a);
    mb = b[DataW-1] ? DataW'(-b) : DataW'(b);
    st_d[0]       = '0;
    st_d[0].mode  = mode_i;
    st_d[0].mag_a = ma;
    st_d[0].den   = mb;
    st_d[0].num   = {ma, {FRACTION_BITS{1'b0}}};
    st_d[0].neg   = a[DataW-1] ^ b[DataW-1];
    st_d[0].dz    = (mode_i == MODE_DIV) && (b == '0);
    case (mode_i)
      MODE_ADD:     st_d[0].res = a + b;
      MODE_SUB:     st_d[0].res = a - b;
      MODE_GT:      st_d[0].cmp = a > b;
      MODE_LT:      st_d[0].cmp = a < b;
      MODE_GE:      st_d[0].cmp = a >= b;
      MODE_LE:      st_d[0].cmp = a <= b;
      MODE_EQ:      st_d[0].cmp = a == b;
      MODE_NE:      st_d[0].cmp = a != b;
      MODE_MIN:     st_d[0].res = (a > b) ? b : a;
      MODE_MAX:     st_d[0].res = (a > b) ? a : b;
      MODE_INC:     st_d[0].res = a + DataW'(1);
      MODE_DEC:     st_d[0].res = a - DataW'(1);
      MODE_TOINT:   st_d[0].res = a >>> FRACTION_BITS;
      MODE_FROMINT: st_d[0].res = a << FRACTION_BITS;
      default:      st_d[0].res = '0;
    endcase
  end

  // One quotient bit per stage; the product is formed on the first hop.
  for (genvar i = 0; i < NumW; i++) begin : g_div
    always_comb begin
      logic [DataW:0] rem_sh;
      logic           take;
      rem_sh = {st_q[i].rem, st_q[i].num[NumW-1]};
      take   = rem_sh >= {1'b0, st_q[i].den};
      st_d[i+1]     = st_q[i];
      st_d[i+1].rem = take ? DataW'(rem_sh - {1'b0, st_q[i].den}) : rem_sh[DataW-1:0];
      st_d[i+1].num = {st_q[i].num[NumW-2:0], 1'b0};
      st_d[i+1].quo = {st_q[i].quo[NumW-2:0], take};
      if (i == 0) begin
        st_d[i+1].prod = st_q[i].mag_a * st_q[i].den;
      end
    end
  end

  // Round and clamp.
  always_comb begin
    stage_t             s;
    logic [2*DataW-1:0] m;
    logic [2*DataW-1:0] q;
    logic [DataW+1:0]   rem2;
    logic [DataW:0]     cl;
    s     = st_q[Depth-1];
    m     = (s.prod + (2*DataW)'(1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
    rem2  = {1'b0, s.rem, 1'b0};
    q     = (2*DataW)'(s.quo) + (2*DataW)'(rem2 >= {2'b0, s.den});
    cl    = '0;
    res_d = s.res;
    sat_d = 1'b0;
    case (s.mode)
      MODE_MUL: begin
        cl    = clamp(s.neg, m);
        res_d = cl[DataW-1:0];
        sat_d = cl[DataW];
      end
      MODE_DIV: begin
        cl = clamp(s.neg, q);
        if (s.dz) begin
          res_d = '0;
        end else begin
          res_d = cl[DataW-1:0];
          sat_d = cl[DataW];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (advance) begin
      vld_q     <= {vld_q[Depth-2:0], in_valid_i};
      out_vld_q <= vld_q[Depth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int i = 0; i < Depth; i++) st_q[i] <= st_d[i];
      res_q <= res_d;
      cmp_q <= st_q[Depth-1].cmp;
      dz_q  <= st_q[Depth-1].dz;
      sat_q <= sat_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign result_value_o   = res_q;
  assign compare_true_o   = cmp_q;
  assign divide_by_zero_o = dz_q;
  assign saturated_o      = sat_q;

endmodule

/* src/fpq_checker.sv */
module fpq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] result_value_o,
  input logic        compare_true_o,
  input logic        divide_by_zero_o,
  input logic        saturated_o
);

  // Input stalls only behind a held result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output back-pressure");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(result_value_o)))
    else $error("stalled result changed");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && divide_by_zero_o) |-> (result_value_o == '0 && !saturated_o))
    else $error("divide by zero beat not cleared");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(compare_true_o && (saturated_o || divide_by_zero_o)))
    else $error("compare flag mixed with arithmetic flag");

endmodule

bind fixed_point_q24_8_alu fpq_checker u_fpq_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .result_value_o   (result_value_o),
  .compare_true_o   (compare_true_o),
  .divide_by_zero_o (divide_by_zero_o),
  .saturated_o      (saturated_o)
);
